/* sv/assert_macros.svh */
// Assertion shorthands. Both sample on clk and are off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IMC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IMC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/imc_pkg.sv */
package imc_pkg;

  localparam int DATA_WIDTH  = 32;
  localparam int COEF_WIDTH  = 18;
  localparam int COEF_FRAC   = COEF_WIDTH - 2;
  localparam int TRIG_FRAC   = 30;
  localparam int COEF_SHIFT  = TRIG_FRAC - COEF_FRAC;
  localparam int ANGLE_WIDTH = 16;
  localparam int SCALE_WIDTH = 16;
  localparam int SCALE_FRAC  = 14;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int NUM_COEF    = 9;
  localparam int COEF_IDX_W  = 4;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = 2;

  // Scaled gyro keeps every bit: signed data times unsigned scale, less the fraction.
  localparam int GP_WIDTH    = DATA_WIDTH + SCALE_WIDTH + 1;
  localparam int GS_WIDTH    = GP_WIDTH - SCALE_FRAC;
  localparam int PROD_WIDTH  = COEF_WIDTH + GS_WIDTH;
  localparam int SUM_WIDTH   = PROD_WIDTH + 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_YAW_OFFSET   = CFG_IDX_W'(0),
    CFG_PITCH_OFFSET = CFG_IDX_W'(1),
    CFG_ROLL_OFFSET  = CFG_IDX_W'(2),
    CFG_GYRO_SCALE_X = CFG_IDX_W'(3),
    CFG_GYRO_SCALE_Y = CFG_IDX_W'(4),
    CFG_GYRO_SCALE_Z = CFG_IDX_W'(5)
  } cfg_reg_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] gyro_x;
    logic signed [DATA_WIDTH-1:0] gyro_y;
    logic signed [DATA_WIDTH-1:0] gyro_z;
    logic signed [DATA_WIDTH-1:0] accel_x;
    logic signed [DATA_WIDTH-1:0] accel_y;
    logic signed [DATA_WIDTH-1:0] accel_z;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] gyro_out_x;
    logic signed [DATA_WIDTH-1:0] gyro_out_y;
    logic signed [DATA_WIDTH-1:0] gyro_out_z;
    logic signed [DATA_WIDTH-1:0] accel_out_x;
    logic signed [DATA_WIDTH-1:0] accel_out_y;
    logic signed [DATA_WIDTH-1:0] accel_out_z;
  } out_item_t;

  typedef logic signed [COEF_WIDTH-1:0] coef_t;
  typedef coef_t [NUM_COEF-1:0] coef_vec_t;

  typedef struct packed {
    logic [ANGLE_WIDTH-1:0] yaw;
    logic [ANGLE_WIDTH-1:0] pitch;
    logic [ANGLE_WIDTH-1:0] roll;
  } angles_t;

  typedef struct packed {
    logic [SCALE_WIDTH-1:0] x;
    logic [SCALE_WIDTH-1:0] y;
    logic [SCALE_WIDTH-1:0] z;
  } gyro_scale_t;

  typedef struct packed {
    logic ready;
    logic busy;
  } build_status_t;

  // Matrix build micro-ops.
  typedef enum logic [2:0] {
    OPD_SY, OPD_CY, OPD_SP, OPD_CP, OPD_SR, OPD_CR, OPD_TMP, OPD_ONE
  } opnd_t;

  typedef enum logic [1:0] {
    ACT_TMP, ACT_SET, ACT_ADD
  } act_t;

  typedef struct packed {
    opnd_t                 a;
    opnd_t                 b;
    act_t                  act;
    logic                  neg;
    logic                  emit;
    logic [COEF_IDX_W-1:0] cidx;
  } mop_t;

endpackage

/* sv/imc_matrix_build.sv */
module imc_matrix_build (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_hit,
  input  imc_pkg::angles_t      angles,
  output imc_pkg::coef_vec_t    coefs,
  output imc_pkg::build_status_t status
);
  import imc_pkg::*;

  localparam int U_W    = 17;
  localparam int R_W    = 13;
  localparam int ACC_W  = 35;
  localparam int RW     = ACC_W - COEF_SHIFT;
  localparam int OP_W   = 5;
  localparam logic [OP_W-1:0] LAST_OP = OP_W'(16);
  localparam logic [U_W-1:0] WRAP_MOD = U_W'(36000);
  localparam logic [U_W-1:0] QUAD_SPAN = U_W'(9000);
  localparam logic [U_W-1:0] HALF_QUAD = U_W'(4500);
  localparam logic signed [17:0] ANGLE_BIAS = 18'sd72000;
  localparam logic [32:0] RAD_C = 33'd191900981;
  localparam logic [30:0] ONE31 = 31'd1 << TRIG_FRAC;
  localparam logic signed [32:0] ONE33 = 33'sd1 <<< TRIG_FRAC;
  localparam logic [3:0] COS_LAST = 4'd4;
  localparam logic [3:0] SIN_LAST = 4'd8;
  localparam logic signed [ACC_W-1:0] COEF_RND =
      (COEF_SHIFT > 0) ? (ACC_W'(1) <<< (COEF_SHIFT - 1)) : '0;
  localparam logic signed [RW-1:0] CMAX =
      {{(RW - COEF_WIDTH + 1){1'b0}}, {(COEF_WIDTH - 1){1'b1}}};
  localparam logic signed [RW-1:0] CMIN = ~CMAX;

  typedef enum logic [15:0] {
    ST_IDLE  = 16'b0000_0000_0000_0001,
    ST_WRAP  = 16'b0000_0000_0000_0010,
    ST_QUAD  = 16'b0000_0000_0000_0100,
    ST_XMUL  = 16'b0000_0000_0000_1000,
    ST_XRND  = 16'b0000_0000_0001_0000,
    ST_X2MUL = 16'b0000_0000_0010_0000,
    ST_X2RND = 16'b0000_0000_0100_0000,
    ST_HMUL  = 16'b0000_0000_1000_0000,
    ST_HRND  = 16'b0000_0001_0000_0000,
    ST_DIV   = 16'b0000_0010_0000_0000,
    ST_HSUB  = 16'b0000_0100_0000_0000,
    ST_SMUL  = 16'b0000_1000_0000_0000,
    ST_SRND  = 16'b0001_0000_0000_0000,
    ST_MMUL  = 16'b0010_0000_0000_0000,
    ST_MACT  = 16'b0100_0000_0000_0000,
    ST_MEMIT = 16'b1000_0000_0000_0000
  } state_t;

  state_t state_r;
  logic   stale_r;
  logic [1:0]  ang_r;
  logic [U_W-1:0] u_r;
  logic [1:0]  quad_r;
  logic        swap_r;
  logic [29:0] x_r;
  logic [29:0] x2_r;
  logic [30:0] t_r;
  logic [30:0] p_r;
  logic [30:0] pc_r;
  logic [3:0]  hk_r;
  logic [OP_W-1:0] op_r;
  logic signed [63:0] prod_r;
  logic signed [32:0] tmp_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [31:0] sin_r [3];
  logic signed [31:0] cos_r [3];
  coef_t coef_r [NUM_COEF];

  logic signed [32:0] ma, mb;
  logic signed [65:0] mprod;
  logic [40:0] xs;
  logic [60:0] rs60;
  logic [61:0] rs61;
  logic [31:0] div_m;
  logic [5:0]  div_s;
  logic [30:0] div_q;
  logic [30:0] t_sub;
  logic signed [31:0] ps_s, pc_s, so_s, co_s, s_fin, c_fin;
  logic signed [63:0] qs;
  logic signed [33:0] q34, term;
  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [RW-1:0] crnd;
  coef_t csat;
  mop_t  cur;

  // Horner divisors 90, 56, 30, 12, 2 (cosine) and 72, 42, 20, 6 (sine) as
  // reciprocals: (p * M) >> S equals p / k for every p below 2^30.
  function automatic logic [31:0] recip_m(input logic [3:0] idx);
    logic [31:0] m;
    unique case (idx)
      4'd0:    m = 32'd1527099484;
      4'd1:    m = 32'd1227133514;
      4'd2:    m = 32'd1145324613;
      4'd3:    m = 32'd1431655766;
      4'd4:    m = 32'd1073741824;
      4'd5:    m = 32'd1908874354;
      4'd6:    m = 32'd1636178018;
      4'd7:    m = 32'd1717986919;
      4'd8:    m = 32'd1431655766;
      default: m = 32'd1073741824;
    endcase
    return m;
  endfunction

  function automatic logic [5:0] recip_s(input logic [3:0] idx);
    logic [5:0] s;
    unique case (idx)
      4'd0:    s = 6'd37;
      4'd1:    s = 6'd36;
      4'd2:    s = 6'd35;
      4'd3:    s = 6'd34;
      4'd4:    s = 6'd31;
      4'd5:    s = 6'd37;
      4'd6:    s = 6'd36;
      4'd7:    s = 6'd35;
      4'd8:    s = 6'd33;
      default: s = 6'd31;
    endcase
    return s;
  endfunction

  function automatic mop_t mk(input opnd_t a, input opnd_t b, input act_t act,
                              input logic neg, input logic emit, input int ci);
    mop_t m;
    m.a    = a;
    m.b    = b;
    m.act  = act;
    m.neg  = neg;
    m.emit = emit;
    m.cidx = COEF_IDX_W'(ci);
    return m;
  endfunction

  // Nine Q30 sums of products of the angle sines and cosines.
  function automatic mop_t op_rom(input logic [OP_W-1:0] idx);
    mop_t m;
    unique case (idx)
      5'd0:    m = mk(OPD_SY,  OPD_SP,  ACT_TMP, 1'b0, 1'b0, 0);
      5'd1:    m = mk(OPD_TMP, OPD_SR,  ACT_SET, 1'b0, 1'b0, 0);
      5'd2:    m = mk(OPD_CY,  OPD_CR,  ACT_ADD, 1'b0, 1'b1, 0);
      5'd3:    m = mk(OPD_CP,  OPD_SY,  ACT_SET, 1'b0, 1'b1, 1);
      5'd4:    m = mk(OPD_CR,  OPD_SY,  ACT_TMP, 1'b0, 1'b0, 0);
      5'd5:    m = mk(OPD_TMP, OPD_SP,  ACT_SET, 1'b1, 1'b0, 0);
      5'd6:    m = mk(OPD_CY,  OPD_SR,  ACT_ADD, 1'b0, 1'b1, 2);
      5'd7:    m = mk(OPD_CY,  OPD_SP,  ACT_TMP, 1'b0, 1'b0, 0);
      5'd8:    m = mk(OPD_TMP, OPD_SR,  ACT_SET, 1'b0, 1'b0, 0);
      5'd9:    m = mk(OPD_CR,  OPD_SY,  ACT_ADD, 1'b1, 1'b1, 3);
      5'd10:   m = mk(OPD_CY,  OPD_CP,  ACT_SET, 1'b0, 1'b1, 4);
      5'd11:   m = mk(OPD_CY,  OPD_CR,  ACT_TMP, 1'b0, 1'b0, 0);
      5'd12:   m = mk(OPD_TMP, OPD_SP,  ACT_SET, 1'b1, 1'b0, 0);
      5'd13:   m = mk(OPD_SY,  OPD_SR,  ACT_ADD, 1'b1, 1'b1, 5);
      5'd14:   m = mk(OPD_CP,  OPD_SR,  ACT_SET, 1'b1, 1'b1, 6);
      5'd15:   m = mk(OPD_SP,  OPD_ONE, ACT_SET, 1'b0, 1'b1, 7);
      5'd16:   m = mk(OPD_CP,  OPD_CR,  ACT_SET, 1'b0, 1'b1, 8);
      default: m = mk(OPD_ONE, OPD_ONE, ACT_TMP, 1'b0, 1'b0, 0);
    endcase
    return m;
  endfunction

  function automatic logic signed [32:0] opnd_val(input opnd_t sel);
    logic signed [32:0] v;
    unique case (sel)
      OPD_SY:  v = 33'(sin_r[0]);
      OPD_CY:  v = 33'(cos_r[0]);
      OPD_SP:  v = 33'(sin_r[1]);
      OPD_CP:  v = 33'(cos_r[1]);
      OPD_SR:  v = 33'(sin_r[2]);
      OPD_CR:  v = 33'(cos_r[2]);
      OPD_TMP: v = tmp_r;
      OPD_ONE: v = ONE33;
      default: v = ONE33;
    endcase
    return v;
  endfunction

  assign cur = op_rom(op_r);

  // Next angle is loaded while the current one finishes.
  logic [ANGLE_WIDTH-1:0] ang_next;
  always_comb begin
    unique case (ang_r)
      2'd0:    ang_next = angles.pitch;
      default: ang_next = angles.roll;
    endcase
  end

  logic signed [17:0] u_ext_next;
  assign u_ext_next = 18'($signed(ang_next)) + ANGLE_BIAS;

  assign div_m = recip_m(hk_r);
  assign div_s = recip_s(hk_r);

  // One shared multiplier for the whole build.
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (1'b1)
      state_r[3]:  begin ma = $signed(33'(u_r[R_W-1:0])); mb = $signed(RAD_C); end
      state_r[5]:  begin ma = $signed(33'(x_r)); mb = $signed(33'(x_r)); end
      state_r[7]:  begin ma = $signed(33'(x2_r)); mb = $signed(33'(t_r)); end
      state_r[9]:  begin ma = $signed(33'(p_r)); mb = $signed({1'b0, div_m}); end
      state_r[11]: begin ma = $signed(33'(x_r)); mb = $signed(33'(t_r)); end
      state_r[13]: begin ma = opnd_val(cur.a); mb = opnd_val(cur.b); end
      default:     begin ma = '0; mb = '0; end
    endcase
  end
  assign mprod = ma * mb;

  assign xs   = 41'(prod_r[39:0]) + 41'd512;
  assign rs60 = prod_r[60:0] + (61'd1 << (TRIG_FRAC - 1));
  assign rs61 = prod_r[61:0] + (62'd1 << (TRIG_FRAC - 1));

  assign div_q = 31'(prod_r[61:0] >> div_s);
  assign t_sub = ONE31 - div_q;

  // Octant swap, then quadrant symmetry.
  assign ps_s = $signed({1'b0, rs61[60:30]});
  assign pc_s = $signed({1'b0, pc_r});
  assign so_s = swap_r ? pc_s : ps_s;
  assign co_s = swap_r ? ps_s : pc_s;
  always_comb begin
    unique case (quad_r)
      2'd0:    begin s_fin = so_s;  c_fin = co_s;  end
      2'd1:    begin s_fin = co_s;  c_fin = -so_s; end
      2'd2:    begin s_fin = -so_s; c_fin = -co_s; end
      default: begin s_fin = -co_s; c_fin = so_s;  end
    endcase
  end

  assign qs   = prod_r + (64'sd1 <<< (TRIG_FRAC - 1));
  assign q34  = qs[63:30];
  assign term = cur.neg ? -q34 : q34;

  assign acc_rnd = acc_r + COEF_RND;
  assign crnd    = acc_rnd[ACC_W-1:COEF_SHIFT];
  always_comb begin
    if (crnd > CMAX) begin
      csat = CMAX[COEF_WIDTH-1:0];
    end else if (crnd < CMIN) begin
      csat = CMIN[COEF_WIDTH-1:0];
    end else begin
      csat = crnd[COEF_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      stale_r <= 1'b1;
      ang_r   <= '0;
      hk_r    <= '0;
      op_r    <= '0;
    end else begin
      if (cfg_hit) begin
        stale_r <= 1'b1;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (stale_r && !cfg_hit) begin
            stale_r <= 1'b0;
            ang_r   <= '0;
            u_r     <= U_W'(18'($signed(angles.yaw)) + ANGLE_BIAS);
            state_r <= ST_WRAP;
          end
        end
        ST_WRAP: begin
          if (u_r >= WRAP_MOD) begin
            u_r <= u_r - WRAP_MOD;
          end else begin
            quad_r  <= '0;
            state_r <= ST_QUAD;
          end
        end
        ST_QUAD: begin
          if (u_r >= QUAD_SPAN) begin
            u_r    <= u_r - QUAD_SPAN;
            quad_r <= quad_r + 2'd1;
          end else begin
            swap_r  <= (u_r > HALF_QUAD);
            u_r     <= (u_r > HALF_QUAD) ? (QUAD_SPAN - u_r) : u_r;
            state_r <= ST_XMUL;
          end
        end
        ST_XMUL:  state_r <= ST_XRND;
        ST_XRND: begin
          x_r     <= xs[39:10];
          state_r <= ST_X2MUL;
        end
        ST_X2MUL: state_r <= ST_X2RND;
        ST_X2RND: begin
          x2_r    <= rs60[59:30];
          t_r     <= ONE31;
          hk_r    <= '0;
          state_r <= ST_HMUL;
        end
        ST_HMUL:  state_r <= ST_HRND;
        ST_HRND: begin
          p_r     <= rs61[60:30];
          state_r <= ST_DIV;
        end
        // The quotient comes out of the multiplier as a reciprocal product.
        ST_DIV:   state_r <= ST_HSUB;
        ST_HSUB: begin
          if (hk_r == COS_LAST) begin
            pc_r    <= t_sub;
            t_r     <= ONE31;
            hk_r    <= hk_r + 4'd1;
            state_r <= ST_HMUL;
          end else if (hk_r == SIN_LAST) begin
            t_r     <= t_sub;
            state_r <= ST_SMUL;
          end else begin
            t_r     <= t_sub;
            hk_r    <= hk_r + 4'd1;
            state_r <= ST_HMUL;
          end
        end
        ST_SMUL:  state_r <= ST_SRND;
        ST_SRND: begin
          sin_r[ang_r] <= s_fin;
          cos_r[ang_r] <= c_fin;
          if (ang_r == 2'd2) begin
            op_r    <= '0;
            state_r <= ST_MMUL;
          end else begin
            u_r     <= U_W'(u_ext_next);
            ang_r   <= ang_r + 2'd1;
            state_r <= ST_WRAP;
          end
        end
        ST_MMUL:  state_r <= ST_MACT;
        ST_MACT: begin
          unique case (cur.act)
            ACT_TMP: tmp_r <= q34[32:0];
            ACT_SET: acc_r <= ACC_W'(term);
            ACT_ADD: acc_r <= acc_r + ACC_W'(term);
            default: tmp_r <= q34[32:0];
          endcase
          if (cur.emit) begin
            state_r <= ST_MEMIT;
          end else begin
            op_r    <= op_r + OP_W'(1);
            state_r <= ST_MMUL;
          end
        end
        ST_MEMIT: begin
          coef_r[cur.cidx] <= csat;
          if (op_r == LAST_OP) begin
            state_r <= ST_IDLE;
          end else begin
            op_r    <= op_r + OP_W'(1);
            state_r <= ST_MMUL;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mprod[63:0];
  end

  always_comb begin
    for (int i = 0; i < NUM_COEF; i++) begin
      coefs[i] = coef_r[i];
    end
  end

  assign status.ready = (state_r == ST_IDLE) && !stale_r;
  assign status.busy  = (state_r != ST_IDLE);

endmodule

/* sv/imc_in_queue.sv */
module imc_in_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  imc_pkg::in_item_t      in_data,
  input  imc_pkg::build_status_t status,
  output logic                   q_valid,
  output imc_pkg::in_item_t      q_data,
  input  logic                   q_pop
);
  import imc_pkg::*;

  in_item_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic              push;

  // Items are held back until the rotation matrix is current.
  assign in_stall = (count_r == (QPTR_W + 1)'(QDEPTH)) || !status.ready;
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign q_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !q_pop) begin
        count_r <= count_r + (QPTR_W + 1)'(1);
      end else if (q_pop && !push) begin
        count_r <= count_r - (QPTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_data;
    end
  end

endmodule

/* sv/imc_rotate_pipe.sv */
module imc_rotate_pipe (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  imc_pkg::in_item_t     q_data,
  output logic                  q_pop,
  input  imc_pkg::coef_vec_t    coefs,
  input  imc_pkg::gyro_scale_t  scales,
  output logic                  out_valid,
  input  logic                  out_stall,
  output imc_pkg::out_item_t    out_data
);
  import imc_pkg::*;

  localparam logic signed [GP_WIDTH-1:0] SC_RND = GP_WIDTH'(1) <<< (SCALE_FRAC - 1);
  localparam logic signed [SUM_WIDTH-1:0] OUT_RND = SUM_WIDTH'(1) <<< (COEF_FRAC - 1);
  localparam int RES_W = SUM_WIDTH - COEF_FRAC;
  localparam logic signed [RES_W-1:0] DMAX =
      {{(RES_W - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
  localparam logic signed [RES_W-1:0] DMIN = ~DMAX;

  logic v1_r, v2_r, v3_r, out_valid_r;
  logic adv;

  logic signed [GP_WIDTH-1:0]   gp1_r [3];
  logic signed [DATA_WIDTH-1:0] ac1_r [3];
  logic signed [GS_WIDTH-1:0]   vec2_r [2][3];
  logic signed [PROD_WIDTH-1:0] pr3_r [2][3][3];
  out_item_t out_data_r;

  logic signed [DATA_WIDTH-1:0]  gin [3];
  logic signed [DATA_WIDTH-1:0]  ain [3];
  logic        [SCALE_WIDTH-1:0] sc  [3];
  logic signed [GP_WIDTH-1:0]    gp_rnd [3];
  logic signed [DATA_WIDTH-1:0]  res [2][3];

  // The whole pipe moves whenever the output register is free or being taken.
  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = adv && q_valid;

  assign gin[0] = q_data.gyro_x;
  assign gin[1] = q_data.gyro_y;
  assign gin[2] = q_data.gyro_z;
  assign ain[0] = q_data.accel_x;
  assign ain[1] = q_data.accel_y;
  assign ain[2] = q_data.accel_z;
  assign sc[0]  = scales.x;
  assign sc[1]  = scales.y;
  assign sc[2]  = scales.z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      gp_rnd[i] = gp1_r[i] + SC_RND;
    end
  end

  always_comb begin
    logic signed [SUM_WIDTH-1:0] s;
    logic signed [RES_W-1:0]     r;
    for (int o = 0; o < 2; o++) begin
      for (int i = 0; i < 3; i++) begin
        s = SUM_WIDTH'(pr3_r[o][i][0]) + SUM_WIDTH'(pr3_r[o][i][1])
            + SUM_WIDTH'(pr3_r[o][i][2]) + OUT_RND;
        r = s[SUM_WIDTH-1:COEF_FRAC];
        if (r > DMAX) begin
          res[o][i] = DMAX[DATA_WIDTH-1:0];
        end else if (r < DMIN) begin
          res[o][i] = DMIN[DATA_WIDTH-1:0];
        end else begin
          res[o][i] = r[DATA_WIDTH-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= q_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        gp1_r[i] <= $signed(gin[i]) * $signed({1'b0, sc[i]});
        ac1_r[i] <= ain[i];
        vec2_r[0][i] <= gp_rnd[i][GP_WIDTH-1:SCALE_FRAC];
        vec2_r[1][i] <= GS_WIDTH'(ac1_r[i]);
      end
      for (int o = 0; o < 2; o++) begin
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            pr3_r[o][i][j] <= $signed(coefs[i*3 + j]) * vec2_r[o][j];
          end
        end
      end
      out_data_r.gyro_out_x  <= res[0][0];
      out_data_r.gyro_out_y  <= res[0][1];
      out_data_r.gyro_out_z  <= res[0][2];
      out_data_r.accel_out_x <= res[1][0];
      out_data_r.accel_out_y <= res[1][1];
      out_data_r.accel_out_z <= res[1][2];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* sv/imu_mounting_correction.sv */
// IMU mounting correction. Each transfer carries a gyro and an accelerometer vector
// (signed Q16.16); the gyro is scaled per axis (unsigned Q2.14) and both vectors are
// rotated by a matrix built from the yaw, pitch and roll offsets (0.01 degree), with
// the results saturated. One sample is taken per clock while in_stall is low; each
// result passes the input queue, then the scale, vector, product and output
// registers of the multiply pipeline. After reset and after any write to registers
// 0 to 5, in_stall stays high while the matrix is rebuilt on one shared 33x33
// multiplier; the rebuild takes longer the further each angle must be wrapped.
// Configuration must be written by the user only while no sample is in flight; the
// block itself does not enforce this. Writes to indexes 6 and 7 are ignored.
module imu_mounting_correction (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  imc_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output imc_pkg::out_item_t                  out_data,
  input  logic                                cfg_we,
  input  logic [imc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [imc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import imc_pkg::*;

  angles_t       angles_r;
  gyro_scale_t   scales_r;
  logic          cfg_hit;
  build_status_t bld_status;
  coef_vec_t     coefs;
  logic          q_valid;
  in_item_t      q_data;
  logic          q_pop;

  assign cfg_hit = cfg_we && (cfg_index <= CFG_IDX_W'(CFG_GYRO_SCALE_Z));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angles_r.yaw   <= '0;
      angles_r.pitch <= '0;
      angles_r.roll  <= '0;
      scales_r.x     <= SCALE_WIDTH'(1) << SCALE_FRAC;
      scales_r.y     <= SCALE_WIDTH'(1) << SCALE_FRAC;
      scales_r.z     <= SCALE_WIDTH'(1) << SCALE_FRAC;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_W'(CFG_YAW_OFFSET):   angles_r.yaw   <= cfg_wdata;
        CFG_IDX_W'(CFG_PITCH_OFFSET): angles_r.pitch <= cfg_wdata;
        CFG_IDX_W'(CFG_ROLL_OFFSET):  angles_r.roll  <= cfg_wdata;
        CFG_IDX_W'(CFG_GYRO_SCALE_X): scales_r.x     <= cfg_wdata;
        CFG_IDX_W'(CFG_GYRO_SCALE_Y): scales_r.y     <= cfg_wdata;
        CFG_IDX_W'(CFG_GYRO_SCALE_Z): scales_r.z     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  imc_matrix_build u_build (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_hit (cfg_hit),
    .angles  (angles_r),
    .coefs   (coefs),
    .status  (bld_status)
  );

  imc_in_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .status   (bld_status),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop)
  );

  imc_rotate_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .coefs     (coefs),
    .scales    (scales_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`include "assert_macros.svh"

  `IMC_ASSERT_SAME(a_accept_needs_matrix, in_valid && !in_stall, bld_status.ready, "sample accepted while the matrix is stale")
  `IMC_ASSERT_NEXT(a_cfg_marks_stale, cfg_hit, !bld_status.ready, "register write did not invalidate the matrix")
  `IMC_ASSERT_SAME(a_ready_not_busy, bld_status.ready, !bld_status.busy, "matrix reported ready during a rebuild")

endmodule

/* tb/sv/tb_imu_mounting_correction.sv */
`timescale 1ns / 1ps

module tb_imu_mounting_correction;
  import imc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = CFG_IDX_W'(6);
  localparam int DRAIN_CYCLES = 20;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  always #2 clk = ~clk;

  imu_mounting_correction dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Register mirror and the rotation matrix it implies.
  logic [CFG_DATA_W-1:0] reg_mirror [6];
  longint rot_coef [NUM_COEF];

  in_item_t  sample_queue [$];
  out_item_t corrected_queue [$];
  int mismatches = 0;
  int results_seen = 0;

  function automatic longint rnd_shift(longint v, int s);
    if (s == 0) return v;
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(longint v, int w);
    longint hi, lo;
    hi = (longint'(1) << (w - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint qmul30(longint a, longint b);
    return rnd_shift(a * b, TRIG_FRAC);
  endfunction

  function automatic longint unsigned taylor(longint unsigned r, bit want_sin);
    longint unsigned x, x2, t;
    int ks [4] = '{72, 42, 20, 6};
    int kc [5] = '{90, 56, 30, 12, 2};
    x = (r * 64'd191900981 + 64'd512) >> 10;
    x2 = (x * x + (64'd1 << 29)) >> 30;
    t = 64'd1 << 30;
    if (want_sin) begin
      foreach (ks[i]) t = (64'd1 << 30) - ((x2 * t + (64'd1 << 29)) >> 30) / ks[i];
      return (x * t + (64'd1 << 29)) >> 30;
    end
    foreach (kc[i]) t = (64'd1 << 30) - ((x2 * t + (64'd1 << 29)) >> 30) / kc[i];
    return t;
  endfunction

  function automatic void angle_sincos(logic [15:0] raw, output longint s, output longint c);
    longint a, u, q, r, ps, pc;
    a = longint'($signed(raw));
    u = (a + 72000) % 36000;
    q = u / 9000;
    r = u % 9000;
    if (r <= 4500) begin
      ps = taylor(r, 1'b1);
      pc = taylor(r, 1'b0);
    end else begin
      ps = taylor(9000 - r, 1'b0);
      pc = taylor(9000 - r, 1'b1);
    end
    case (q)
      0: begin s = ps;  c = pc;  end
      1: begin s = pc;  c = -ps; end
      2: begin s = -ps; c = -pc; end
      default: begin s = -pc; c = ps; end
    endcase
  endfunction

  function automatic void rebuild_rotation();
    longint sy, cy, sp, cp, sr, cr;
    longint m [NUM_COEF];
    angle_sincos(reg_mirror[CFG_YAW_OFFSET], sy, cy);
    angle_sincos(reg_mirror[CFG_PITCH_OFFSET], sp, cp);
    angle_sincos(reg_mirror[CFG_ROLL_OFFSET], sr, cr);
    m[0] = qmul30(cy, cr) + qmul30(qmul30(sy, sp), sr);
    m[1] = qmul30(cp, sy);
    m[2] = qmul30(cy, sr) - qmul30(qmul30(cr, sy), sp);
    m[3] = qmul30(qmul30(cy, sp), sr) - qmul30(cr, sy);
    m[4] = qmul30(cy, cp);
    m[5] = -qmul30(sy, sr) - qmul30(qmul30(cy, cr), sp);
    m[6] = -qmul30(cp, sr);
    m[7] = sp;
    m[8] = qmul30(cp, cr);
    foreach (m[i]) rot_coef[i] = clamp(rnd_shift(m[i], COEF_SHIFT), COEF_WIDTH);
  endfunction

  // The vector is split into an integer part and COEF_FRAC low bits so that the
  // fraction products are rounded once per row.
  function automatic void rotate_vec(longint v [3], output longint res [3]);
    longint whole, part, lo;
    for (int i = 0; i < 3; i++) begin
      whole = 0;
      part = 0;
      for (int j = 0; j < 3; j++) begin
        lo = v[j] & ((longint'(1) << COEF_FRAC) - 1);
        whole += rot_coef[i*3+j] * (v[j] >>> COEF_FRAC);
        part += rot_coef[i*3+j] * lo;
      end
      res[i] = clamp(whole + rnd_shift(part, COEF_FRAC), DATA_WIDTH);
    end
  endfunction

  function automatic out_item_t correct_sample(in_item_t s);
    longint g [3], a [3], gr [3], ar [3];
    out_item_t o;
    g[0] = rnd_shift(longint'(s.gyro_x) * longint'(reg_mirror[CFG_GYRO_SCALE_X]), SCALE_FRAC);
    g[1] = rnd_shift(longint'(s.gyro_y) * longint'(reg_mirror[CFG_GYRO_SCALE_Y]), SCALE_FRAC);
    g[2] = rnd_shift(longint'(s.gyro_z) * longint'(reg_mirror[CFG_GYRO_SCALE_Z]), SCALE_FRAC);
    a[0] = longint'(s.accel_x);
    a[1] = longint'(s.accel_y);
    a[2] = longint'(s.accel_z);
    rotate_vec(g, gr);
    rotate_vec(a, ar);
    o.gyro_out_x = gr[0][DATA_WIDTH-1:0];
    o.gyro_out_y = gr[1][DATA_WIDTH-1:0];
    o.gyro_out_z = gr[2][DATA_WIDTH-1:0];
    o.accel_out_x = ar[0][DATA_WIDTH-1:0];
    o.accel_out_y = ar[1][DATA_WIDTH-1:0];
    o.accel_out_z = ar[2][DATA_WIDTH-1:0];
    return o;
  endfunction

  // Driver: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    logic nxt_valid;
    in_item_t nxt_data;
    nxt_valid = in_valid;
    nxt_data = in_data;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        corrected_queue.push_back(correct_sample(in_data));
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (sample_queue.size() > 0) begin
          nxt_data = sample_queue.pop_front();
          nxt_valid = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 30);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
    in_valid <= nxt_valid;
    in_data <= nxt_data;
  end

  // Receiver stall pattern, with one long hold-off that backs up the block.
  int rx_mode = 0;
  int rx_left = 0;
  int hold_cycles = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    logic nxt_stall;
    if (!hold_done && results_seen >= 120) begin
      hold_done = 1'b1;
      hold_cycles = 400;
    end
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(5, 60);
    end else begin
      rx_left--;
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      nxt_stall = 1'b1;
    end else begin
      case (rx_mode)
        0: nxt_stall = 1'b0;
        1: nxt_stall = ($urandom_range(0, 1) == 0);
        2: nxt_stall = ($urandom_range(0, 4) != 0);
        default: nxt_stall = ($urandom_range(0, 4) == 0);
      endcase
    end
    out_stall <= nxt_stall;
  end

  // Monitor.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (corrected_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected transfer: %p", out_data);
      end else begin
        want = corrected_queue.pop_front();
        if (want.gyro_out_x !== out_data.gyro_out_x || want.gyro_out_y !== out_data.gyro_out_y ||
            want.gyro_out_z !== out_data.gyro_out_z ||
            want.accel_out_x !== out_data.accel_out_x ||
            want.accel_out_y !== out_data.accel_out_y ||
            want.accel_out_z !== out_data.accel_out_z) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, out_data);
        end
      end
    end
  end

  task automatic wait_idle();
    do @(posedge clk);
    while (sample_queue.size() != 0 || in_valid || corrected_queue.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx < 6) begin
      reg_mirror[idx] = val;
      rebuild_rotation();
    end
  endtask

  task automatic set_config(logic [15:0] yaw, logic [15:0] pitch, logic [15:0] roll,
                            logic [15:0] sx, logic [15:0] sy, logic [15:0] sz);
    wait_idle();
    reg_write(CFG_YAW_OFFSET, yaw);
    reg_write(CFG_PITCH_OFFSET, pitch);
    reg_write(CFG_ROLL_OFFSET, roll);
    reg_write(CFG_GYRO_SCALE_X, sx);
    reg_write(CFG_GYRO_SCALE_Y, sy);
    reg_write(CFG_GYRO_SCALE_Z, sz);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_random(int n);
    in_item_t s;
    repeat (n) begin
      s = {rand_word(), rand_word(), rand_word(), rand_word(), rand_word(), rand_word()};
      sample_queue.push_back(s);
    end
  endtask

  initial begin
    reg_mirror = '{16'd0, 16'd0, 16'd0, 16'd16384, 16'd16384, 16'd16384};
    rebuild_rotation();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Identity matrix: extremes, zero, and a one-sided full-scale vector.
    sample_queue.push_back('0);
    sample_queue.push_back({6{32'h7FFF_FFFF}});
    sample_queue.push_back({6{32'h8000_0000}});
    sample_queue.push_back({6{32'hFFFF_FFFF}});
    sample_queue.push_back({32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000,
                            32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001});
    add_random(50);

    // Largest scales overflow the output; zero scale clears the gyro.
    set_config(16'd4500, 16'd9000, 16'($signed(-18000)), 16'hFFFF, 16'd0, 16'd32768);
    sample_queue.push_back({6{32'h7FFF_FFFF}});
    sample_queue.push_back({6{32'h8000_0000}});
    sample_queue.push_back({32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000});
    add_random(50);

    // Angles beyond half a turn wrap around.
    set_config(16'h7FFF, 16'h8000, 16'd18000, 16'd16384, 16'hFFFF, 16'd1);
    sample_queue.push_back({6{32'h7FFF_FFFF}});
    add_random(50);

    // Writes to unused indexes are ignored.
    wait_idle();
    reg_write(CFG_UNUSED_IDX, 16'h1234);
    reg_write(CFG_UNUSED_IDX + 1'b1, 16'hFFFF);
    @(posedge clk);
    cfg_we <= 1'b0;
    add_random(40);

    set_config(16'($signed(-18000)), 16'($signed(-9000)), 16'd9000, 16'd0, 16'd0, 16'd0);
    add_random(30);

    for (int p = 0; p < 4; p++) begin
      set_config(16'($signed($urandom_range(0, 36000)) - 18000),
                 16'($signed($urandom_range(0, 36000)) - 18000),
                 16'($urandom), 16'($urandom_range(8000, 24000)), 16'($urandom),
                 16'($urandom_range(0, 65535)));
      add_random(45);
    end

    wait_idle();
    if (mismatches == 0 && corrected_queue.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end

endmodule
